// ----- design/slfe_pkg.sv -----
// ----------------------------------------------------------------------------
// slfe_pkg
// Shared types, constants and pointer helpers for the sync/length deframer.
// ----------------------------------------------------------------------------
package slfe_pkg;

    // Ring geometry; any depth from 16 up to 1024 works, power of two or not
    localparam int RING_DEPTH = 1024;
    localparam int PTR_W      = $clog2(RING_DEPTH);

    // Field widths fixed by the interface
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 10;
    localparam int FREE_W = 10;
    localparam int SIZE_W = 17;

    // Framing constants
    localparam logic [BYTE_W-1:0] SYNC_FIRST     = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND    = 8'h55;
    localparam int                MIN_HELD       = 8;
    localparam int                FRAME_OVERHEAD = 6;
    localparam logic [LEN_W-1:0]  MAX_FRAME_RST  = 10'd256;

    // Command codes
    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] data_byte;
    } in_t;

    typedef struct packed {
        logic              accepted;
        logic              frame_valid;
        logic [BYTE_W-1:0] frame_byte;
        logic [LEN_W-1:0]  frame_length;
        logic              first_of_frame;
        logic              last_of_frame;
        logic [FREE_W-1:0] free_space;
    } out_t;

    // Ring read address source
    typedef enum logic [2:0] {
        RD_RP   = 3'd0,
        RD_IDX  = 3'd1,
        RD_IDX1 = 3'd2,
        RD_IDX2 = 3'd3,
        RD_IDX3 = 3'd4
    } rd_sel_t;

    // What the closing step of an item does
    typedef enum logic [1:0] {
        KIND_FEED = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_NONE = 2'd2
    } kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    latch_item;
        logic    scan_init;
        logic    scan_advance;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    latch_len_lo;
        logic    latch_size;
        logic    start_frame;
        logic    commit;
        kind_t   kind;
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic item_pull;
        logic in_frame;
        logic left_nz;
        logic avail_ge_min;
        logic byte_is_sync1;
        logic byte_is_sync2;
        logic size_over_max;
        logic size_over_avail;
        logic out_free;
    } sts_t;

    // Pointer plus a small offset, wrapped into the ring
    function automatic ptr_t ptr_add(ptr_t p, logic [1:0] k);
        logic [PTR_W:0] sum;
        sum = {1'b0, p} + (PTR_W+1)'(k);
        if (sum >= (PTR_W+1)'(RING_DEPTH)) begin
            sum = sum - (PTR_W+1)'(RING_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Bytes held between read and write pointer
    function automatic ptr_t held_of(ptr_t rp, ptr_t wp);
        logic [PTR_W:0] diff;
        diff = {1'b0, wp} + (PTR_W+1)'(RING_DEPTH) - {1'b0, rp};
        if (diff >= (PTR_W+1)'(RING_DEPTH)) begin
            diff = diff - (PTR_W+1)'(RING_DEPTH);
        end
        return diff[PTR_W-1:0];
    endfunction

    // Free entries; one slot always stays empty
    function automatic ptr_t room_of(ptr_t rp, ptr_t wp);
        return ptr_t'(RING_DEPTH - 1) - held_of(rp, wp);
    endfunction

endpackage

// ----- design/slfe_ram.sv -----
// ----------------------------------------------------------------------------
// slfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/slfe_dp.sv -----
// ----------------------------------------------------------------------------
// slfe_dp
// Datapath: ring pointers, frame state, sync scan registers, the ring RAM,
// the configuration register and the result register.
// ----------------------------------------------------------------------------
module slfe_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  slfe_pkg::ctl_t                 ctl,
    output slfe_pkg::sts_t                 sts,
    input  slfe_pkg::in_t                  s_data,
    input  logic                           cfg_wr_en,
    input  logic [slfe_pkg::LEN_W-1:0]     cfg_wr_data,
    output slfe_pkg::out_t                 m_data,
    output logic                           m_valid,
    input  logic                           m_ready
);
    import slfe_pkg::*;

    in_t                item_reg;
    ptr_t               rp_reg, rp_next;
    ptr_t               wp_reg, wp_next;
    logic               in_frame_reg, in_frame_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic [LEN_W-1:0]   cur_len_reg, cur_len_next;
    logic [LEN_W-1:0]   max_reg;
    ptr_t               idx_reg, idx_next;
    ptr_t               avail_reg, avail_next;
    logic [BYTE_W-1:0]  len_lo_reg;
    logic [SIZE_W-1:0]  size_reg;
    out_t               out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    ptr_t               room;
    ptr_t               raddr;
    logic               ram_we;
    logic [BYTE_W-1:0]  rdata;
    logic [SIZE_W-1:0]  size_calc;

    assign room = room_of(rp_reg, wp_reg);

    // Ring storage
    assign ram_we = ctl.commit && (ctl.kind == KIND_FEED) && (room != '0);

    always_comb begin
        unique case (ctl.rd_sel)
            RD_RP:   raddr = rp_reg;
            RD_IDX:  raddr = idx_reg;
            RD_IDX1: raddr = ptr_add(idx_reg, 2'd1);
            RD_IDX2: raddr = ptr_add(idx_reg, 2'd2);
            RD_IDX3: raddr = ptr_add(idx_reg, 2'd3);
            default: raddr = rp_reg;
        endcase
    end

    slfe_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (item_reg.data_byte),
        .re    (ctl.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Header size from the length bytes, wide enough never to wrap
    assign size_calc = SIZE_W'({rdata, len_lo_reg}) + SIZE_W'(FRAME_OVERHEAD);

    // Status toward the controller
    always_comb begin
        sts.item_pull       = (item_reg.command == CMD_PULL);
        sts.in_frame        = in_frame_reg;
        sts.left_nz         = (left_reg != '0);
        sts.avail_ge_min    = (avail_reg >= ptr_t'(MIN_HELD));
        sts.byte_is_sync1   = (rdata == SYNC_FIRST);
        sts.byte_is_sync2   = (rdata == SYNC_SECOND);
        sts.size_over_max   = (size_reg > SIZE_W'(max_reg));
        sts.size_over_avail = (size_reg > SIZE_W'(avail_reg));
        sts.out_free        = !out_valid_reg || m_ready;
    end

    // Scan, frame and pointer updates
    always_comb begin
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        in_frame_next  = in_frame_reg;
        left_next      = left_reg;
        cur_len_next   = cur_len_reg;
        idx_next       = idx_reg;
        avail_next     = avail_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;

        if (ctl.scan_init) begin
            idx_next   = rp_reg;
            avail_next = held_of(rp_reg, wp_reg);
        end
        if (ctl.scan_advance) begin
            idx_next   = ptr_add(idx_reg, 2'd1);
            avail_next = avail_reg - ptr_t'(1);
        end
        if (ctl.start_frame) begin
            rp_next       = idx_reg;
            in_frame_next = 1'b1;
            left_next     = LEN_W'(size_reg);
            cur_len_next  = LEN_W'(size_reg);
        end

        if (ctl.commit) begin
            out_next       = '0;
            out_valid_next = 1'b1;
            unique case (ctl.kind)
                KIND_FEED: begin
                    if (room != '0) begin
                        wp_next           = ptr_add(wp_reg, 2'd1);
                        out_next.accepted = 1'b1;
                    end
                end
                KIND_BYTE: begin
                    out_next.frame_valid    = 1'b1;
                    out_next.frame_byte     = rdata;
                    out_next.frame_length   = cur_len_reg;
                    out_next.first_of_frame = (left_reg == cur_len_reg);
                    out_next.last_of_frame  = (left_reg == LEN_W'(1));
                    rp_next                 = ptr_add(rp_reg, 2'd1);
                    left_next               = left_reg - LEN_W'(1);
                    if (left_reg == LEN_W'(1)) begin
                        in_frame_next = 1'b0;
                    end
                end
                KIND_NONE: begin
                    in_frame_next = 1'b0;
                end
                default: begin
                    in_frame_next = in_frame_reg;
                end
            endcase
            out_next.free_space = FREE_W'(room_of(rp_next, wp_next));
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg        <= '0;
            wp_reg        <= '0;
            in_frame_reg  <= 1'b0;
            left_reg      <= '0;
            cur_len_reg   <= '0;
            max_reg       <= MAX_FRAME_RST;
            out_valid_reg <= 1'b0;
        end else begin
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            in_frame_reg  <= in_frame_next;
            left_reg      <= left_next;
            cur_len_reg   <= cur_len_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                max_reg <= cfg_wr_data;
            end
        end
    end

    // Payload and scan working registers
    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        avail_reg <= avail_next;
        out_reg   <= out_next;
        if (ctl.latch_item) begin
            item_reg <= s_data;
        end
        if (ctl.latch_len_lo) begin
            len_lo_reg <= rdata;
        end
        if (ctl.latch_size) begin
            size_reg <= size_calc;
        end
    end

    assign m_data  = out_reg;
    assign m_valid = out_valid_reg;

endmodule

// ----- design/slfe_ctrl.sv -----
// ----------------------------------------------------------------------------
// slfe_ctrl
// Controller: sequences one transfer at a time through dispatch, the sync
// scan and the closing commit.
// ----------------------------------------------------------------------------
module slfe_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  slfe_pkg::sts_t sts,
    output slfe_pkg::ctl_t ctl
);
    import slfe_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_DISPATCH = 9'b000000010,
        ST_CAND     = 9'b000000100,
        ST_B0       = 9'b000001000,
        ST_B1       = 9'b000010000,
        ST_B2       = 9'b000100000,
        ST_B3       = 9'b001000000,
        ST_SIZE     = 9'b010000000,
        ST_FINISH   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        ctl        = '0;
        ctl.rd_sel = RD_RP;
        ctl.kind   = kind_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.latch_item = 1'b1;
                    state_next     = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (!sts.item_pull) begin
                    kind_next  = KIND_FEED;
                    state_next = ST_FINISH;
                end else if (sts.in_frame) begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_RP;
                    kind_next  = KIND_BYTE;
                    state_next = ST_FINISH;
                end else begin
                    ctl.scan_init = 1'b1;
                    state_next    = ST_CAND;
                end
            end
            ST_CAND: begin
                if (!sts.avail_ge_min) begin
                    kind_next  = KIND_NONE;
                    state_next = ST_FINISH;
                end else begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_IDX;
                    state_next = ST_B0;
                end
            end
            ST_B0: begin
                if (sts.byte_is_sync1) begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_IDX1;
                    state_next = ST_B1;
                end else begin
                    ctl.scan_advance = 1'b1;
                    state_next       = ST_CAND;
                end
            end
            ST_B1: begin
                if (sts.byte_is_sync2) begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_IDX2;
                    state_next = ST_B2;
                end else begin
                    ctl.scan_advance = 1'b1;
                    state_next       = ST_CAND;
                end
            end
            ST_B2: begin
                ctl.latch_len_lo = 1'b1;
                ctl.rd_en        = 1'b1;
                ctl.rd_sel       = RD_IDX3;
                state_next       = ST_B3;
            end
            ST_B3: begin
                ctl.latch_size = 1'b1;
                state_next     = ST_SIZE;
            end
            ST_SIZE: begin
                // Skip oversized headers, wait on incomplete frames, else start
                priority if (sts.size_over_max) begin
                    ctl.scan_advance = 1'b1;
                    state_next       = ST_CAND;
                end else if (sts.size_over_avail) begin
                    kind_next  = KIND_NONE;
                    state_next = ST_FINISH;
                end else begin
                    ctl.start_frame = 1'b1;
                    ctl.rd_en       = 1'b1;
                    ctl.rd_sel      = RD_IDX;
                    kind_next       = KIND_BYTE;
                    state_next      = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Hold until the result register can take the transfer
                if (sts.out_free) begin
                    ctl.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_NONE;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

// ----- design/sync_length_frame_extractor.sv -----
// ----------------------------------------------------------------------------
// sync_length_frame_extractor
// Byte ring buffer with a sync-word / length deframer.
// ----------------------------------------------------------------------------
// Feed transfers store bytes into a ring of slfe_pkg::RING_DEPTH entries (one
// entry stays free); pull transfers return the next byte of a complete frame
// (0xAA 0x55, 16-bit little-endian length L, L payload bytes, 2 trailer bytes,
// L+6 bytes total), each with one result transfer. The block works on one
// transfer at a time: a feed or an in-frame pull is accepted, dispatched and
// committed to the result register, and the input is ready again only after
// that commit. A pull that must locate a frame scans the ring one position at
// a time through the single read port of the ring RAM: a first sync byte adds
// a read of the second, a full header adds the two length reads and the size
// check, and the scan gives up when fewer than MIN_HELD bytes remain. A
// waiting result sits in an output register, so the next transfer
// is accepted while it waits and stalls only in its last step if the older
// result is still unread. The frame size limit (reset 256) is written through
// cfg_wr_en/cfg_wr_data and must only change while no transfer is in work.
// ----------------------------------------------------------------------------
module sync_length_frame_extractor (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  slfe_pkg::in_t              s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output slfe_pkg::out_t             m_data,
    input  logic                       cfg_wr_en,
    input  logic [slfe_pkg::LEN_W-1:0] cfg_wr_data
);
    import slfe_pkg::*;

    ctl_t ctl;
    sts_t sts;

    slfe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    slfe_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .sts         (sts),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_data      (m_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready)
    );

    // One transfer in flight: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while previous transfer still in work");

    // Commit only when the result register is free
    a_commit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.commit |-> sts.out_free)
        else $error("result committed over a pending result");

    // An open frame always has bytes left
    a_frame_left: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.in_frame |-> sts.left_nz)
        else $error("frame open with no bytes left");

    // A frame starts on its sync byte
    a_first_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.first_of_frame |->
            m_data.frame_valid && (m_data.frame_byte == SYNC_FIRST))
        else $error("first frame byte is not the sync byte");

endmodule

// ----- dv/sync_length_frame_extractor_tb.sv -----
// ----------------------------------------------------------------------------
// sync_length_frame_extractor_tb
// Self-checking bench for the ring buffer and sync/length deframer.
// ----------------------------------------------------------------------------
// A queue of feed and pull transfers is filled phase by phase and sent in
// random bursts. Every accepted transfer runs through a local deframer
// model, and its result is queued. The result side stalls on a rotating
// pattern, and each returned result is compared field by field. Phases cover
// short directed cases, a full ring and the lowest and highest frame size
// limits. Random framed traffic is mixed with noise and broken headers.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sync_length_frame_extractor_tb;

    import slfe_pkg::*;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    in_t                  s_data      = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    out_t                 m_data;
    logic                 cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0]     cfg_wr_data = '0;

    // Transfers waiting to be sent and results waiting to come back
    in_t                  cmd_q[$];
    out_t                 due_results[$];
    logic [BYTE_W-1:0]    seq_bytes[$];

    // Deframer image: ring contents, pointers, frame progress, size limit
    logic [BYTE_W-1:0]    ring_img [0:RING_DEPTH-1];
    ptr_t                 rd_ptr      = '0;
    ptr_t                 wr_ptr      = '0;
    logic                 frm_active  = 1'b0;
    logic [LEN_W-1:0]     frm_left    = '0;
    logic [LEN_W-1:0]     frm_size    = '0;
    logic [LEN_W-1:0]     max_cfg     = MAX_FRAME_RST;

    int unsigned          err_count    = 0;
    int unsigned          gen_count    = 0;
    int unsigned          results_seen = 0;
    int unsigned          frames_seen  = 0;
    int unsigned          drops_seen   = 0;

    int unsigned          burst_left = 0;
    int unsigned          gap_left   = 0;
    logic [15:0]          stall_pat  = 16'hFFFF;
    int unsigned          stall_tick = 0;
    out_t                 next_due;

    sync_length_frame_extractor u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Deframer model
    // ------------------------------------------------------------------------
    function automatic ptr_t ptr_step(input ptr_t p, input int unsigned k);
        return ptr_t'((p + k) % RING_DEPTH);
    endfunction

    function automatic int unsigned held_bytes();
        return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
    endfunction

    function automatic int unsigned room_bytes();
        return RING_DEPTH - 1 - held_bytes();
    endfunction

    // Scan held bytes for a complete frame within the size limit; start it
    function automatic void frame_search();
        int unsigned       avail;
        ptr_t              idx;
        logic [SIZE_W-1:0] fsize;
        bit                done;
        avail = held_bytes();
        idx   = rd_ptr;
        done  = 1'b0;
        while (!done && avail >= MIN_HELD) begin
            if (ring_img[idx] == SYNC_FIRST && ring_img[ptr_step(idx, 1)] == SYNC_SECOND) begin
                fsize = SIZE_W'({ring_img[ptr_step(idx, 3)], ring_img[ptr_step(idx, 2)]})
                        + SIZE_W'(FRAME_OVERHEAD);
                // oversized headers fall through and the scan moves on by one
                if (fsize <= SIZE_W'(max_cfg)) begin
                    done = 1'b1;
                    // an incomplete frame leaves the read pointer alone
                    if (fsize <= avail) begin
                        rd_ptr     = idx;
                        frm_active = 1'b1;
                        frm_left   = fsize[LEN_W-1:0];
                        frm_size   = fsize[LEN_W-1:0];
                    end
                end
            end
            if (!done) begin
                idx   = ptr_step(idx, 1);
                avail = avail - 1;
            end
        end
    endfunction

    // Apply one transfer to the model and return the result it produces
    function automatic out_t deframe_step(input in_t it);
        out_t r;
        r = '0;
        if (it.command == CMD_FEED) begin
            if (room_bytes() != 0) begin
                ring_img[wr_ptr] = it.data_byte;
                wr_ptr     = ptr_step(wr_ptr, 1);
                r.accepted = 1'b1;
            end else begin
                drops_seen++;
            end
        end else begin
            if (!frm_active) begin
                frame_search();
            end
            if (frm_active && frm_left != 0) begin
                r.frame_valid    = 1'b1;
                r.frame_byte     = ring_img[rd_ptr];
                r.frame_length   = frm_size;
                r.first_of_frame = (frm_left == frm_size);
                rd_ptr   = ptr_step(rd_ptr, 1);
                frm_left = frm_left - 1'b1;
                if (frm_left == 0) begin
                    r.last_of_frame = 1'b1;
                    frm_active      = 1'b0;
                end
            end else begin
                frm_active = 1'b0;
            end
        end
        r.free_space = FREE_W'(room_bytes());
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Input driver: bursts of transfers with random gaps
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_data     <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            // predict on every accepted transfer
            if (s_valid && s_ready) begin
                due_results.push_back(deframe_step(s_data));
            end
            if (s_valid && !s_ready) begin
                // hold the offered transfer until it is taken
            end else if (gap_left != 0) begin
                gap_left = gap_left - 1;
                s_valid  <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                s_valid <= 1'b1;
                s_data  <= cmd_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 32);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor and ready pattern
    // ------------------------------------------------------------------------
    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_pat  = 16'hFFFF;
            stall_tick = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_data);
                    err_count++;
                end else begin
                    next_due = due_results.pop_front();
                    check_field("accepted", next_due.accepted, m_data.accepted);
                    check_field("frame_valid", next_due.frame_valid, m_data.frame_valid);
                    check_field("frame_byte", next_due.frame_byte, m_data.frame_byte);
                    check_field("frame_length", next_due.frame_length, m_data.frame_length);
                    check_field("first_of_frame", next_due.first_of_frame,
                                m_data.first_of_frame);
                    check_field("last_of_frame", next_due.last_of_frame,
                                m_data.last_of_frame);
                    check_field("free_space", next_due.free_space, m_data.free_space);
                    if (next_due.last_of_frame) begin
                        frames_seen++;
                    end
                end
            end
            // rotate the stall pattern or pick a fresh random one
            stall_tick++;
            if (stall_tick % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pat = 16'hFFFF;
                    1: stall_pat = 16'($urandom);
                    2: stall_pat = 16'($urandom | $urandom);
                    default: stall_pat = 16'($urandom & $urandom) | 16'h0001;
                endcase
            end else begin
                stall_pat = {stall_pat[0], stall_pat[15:1]};
            end
            m_ready <= stall_pat[0];
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic push_cmd(input logic c, input logic [BYTE_W-1:0] b);
        in_t it;
        it.command   = c;
        it.data_byte = b;
        cmd_q.push_back(it);
        gen_count++;
    endtask

    task automatic add_header(input logic [15:0] len);
        seq_bytes.push_back(SYNC_FIRST);
        seq_bytes.push_back(SYNC_SECOND);
        seq_bytes.push_back(len[7:0]);
        seq_bytes.push_back(len[15:8]);
    endtask

    task automatic add_random_bytes(input int unsigned n, input bit no_sync);
        logic [BYTE_W-1:0] b;
        repeat (n) begin
            b = BYTE_W'($urandom);
            if (no_sync && b == SYNC_FIRST) begin
                b = ~b;
            end
            seq_bytes.push_back(b);
        end
    endtask

    // Send staged bytes as feeds, optionally with early pulls, then the pulls
    task automatic emit_sequence(input int unsigned n_pulls, input bit early);
        while (seq_bytes.size() != 0) begin
            push_cmd(CMD_FEED, seq_bytes.pop_front());
            if (early && $urandom_range(0, 5) == 0) begin
                push_cmd(CMD_PULL, BYTE_W'($urandom));
            end
        end
        repeat (n_pulls) push_cmd(CMD_PULL, BYTE_W'($urandom));
    endtask

    // Wait until every transfer is sent and every result has come back
    task automatic wait_idle();
        do @(negedge aclk);
        while (cmd_q.size() != 0 || s_valid || due_results.size() != 0);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_max_frame(input logic [LEN_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        max_cfg   = v;
    endtask

    // Mostly well-formed frames with random content; the rest broken or noise
    task automatic run_random(input int unsigned n);
        int unsigned stop_at, pick, lim, len;
        logic [BYTE_W-1:0] b;
        stop_at = gen_count + n;
        while (gen_count < stop_at) begin
            pick = $urandom_range(0, 99);
            lim  = (max_cfg >= FRAME_OVERHEAD) ? max_cfg - FRAME_OVERHEAD : 0;
            if (pick < 70) begin
                if ($urandom_range(0, 1) == 0) begin
                    add_random_bytes($urandom_range(1, 3), 1'b1);
                end
                if ($urandom_range(0, 19) == 0) begin
                    len = $urandom_range(0, (lim > 200) ? 200 : lim);
                end else if ($urandom_range(0, 9) == 0 && max_cfg <= 300) begin
                    // size right at the limit or one over it
                    len = lim + $urandom_range(0, 1);
                end else begin
                    len = $urandom_range(0, (lim > 24) ? 24 : lim);
                end
                add_header(16'(len));
                add_random_bytes(len + 2, 1'b0);
                emit_sequence(len + FRAME_OVERHEAD + $urandom_range(0, 2), 1'b1);
            end else if (pick < 85) begin
                case ($urandom_range(0, 2))
                    0: begin
                        // first sync byte without the second
                        seq_bytes.push_back(SYNC_FIRST);
                        b = BYTE_W'($urandom);
                        seq_bytes.push_back((b == SYNC_SECOND) ? ~b : b);
                        add_random_bytes($urandom_range(2, 6), 1'b1);
                        emit_sequence($urandom_range(1, 3), 1'b1);
                    end
                    1: begin
                        // length far beyond any limit, 16-bit wrap included
                        if ($urandom_range(0, 3) == 0) begin
                            add_header(16'hFFFA + 16'($urandom_range(0, 5)));
                        end else begin
                            add_header({8'($urandom_range(4, 255)), 8'($urandom)});
                        end
                        add_random_bytes($urandom_range(0, 4), 1'b1);
                        emit_sequence($urandom_range(1, 2), 1'b1);
                    end
                    default: begin
                        // header with part of its body only
                        len = $urandom_range(4, 20);
                        add_header(16'(len));
                        add_random_bytes($urandom_range(0, len), 1'b0);
                        emit_sequence($urandom_range(1, 3), 1'b1);
                    end
                endcase
            end else begin
                add_random_bytes($urandom_range(1, 8), 1'b0);
                emit_sequence($urandom_range(0, 3), 1'b1);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty pull, short ring, wrapped length, frame behind a
        // skipped header
        push_cmd(CMD_PULL, 8'hFF);
        add_header(16'h0000);
        seq_bytes.push_back(8'hC3);
        seq_bytes.push_back(8'h3C);
        emit_sequence(1, 1'b0);
        add_header(16'hFFFA);
        emit_sequence(6, 1'b0);
        add_header(16'h0001);
        seq_bytes.push_back(8'h5A);
        emit_sequence(1, 1'b0);
        seq_bytes.push_back(8'h00);
        seq_bytes.push_back(8'hFF);
        seq_bytes.push_back(8'h11);
        emit_sequence(8, 1'b0);
        wait_idle();

        // Full ring: noise up to a short frame at the very end, then dropped
        // feeds; the scan crosses the whole ring and discards the noise
        set_max_frame(10'd1023);
        add_random_bytes(room_bytes() - 8, 1'b1);
        add_header(16'h0000);
        add_random_bytes(2, 1'b0);
        add_random_bytes(5, 1'b1);
        emit_sequence(8, 1'b0);
        wait_idle();

        // Limit below the smallest frame rejects it; one more admits it
        set_max_frame(10'd5);
        add_header(16'h0000);
        add_random_bytes(4, 1'b1);
        emit_sequence(2, 1'b0);
        wait_idle();
        set_max_frame(10'd6);
        emit_sequence(7, 1'b0);
        add_header(16'h0001);
        add_random_bytes(3, 1'b1);
        emit_sequence(1, 1'b0);
        wait_idle();

        // Random traffic across several limits
        set_max_frame(MAX_FRAME_RST);
        run_random(80);
        wait_idle();
        set_max_frame(LEN_W'($urandom_range(6, 1023)));
        run_random(60);
        wait_idle();
        run_random(60);
        wait_idle();
        set_max_frame(10'd40);
        run_random(80);
        wait_idle();
        set_max_frame(10'd1023);
        run_random(80);
        wait_idle();
        set_max_frame(LEN_W'($urandom_range(6, 120)));
        run_random(80);
        wait_idle();
        repeat (20) @(posedge aclk);

        $display("Summary: %0d results checked, %0d frames extracted, %0d bytes dropped.",
                 results_seen, frames_seen, drops_seen);
        $display("Summary: size limits 5 to 1023, full ring, broken headers and noise.");
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #250_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/slfe_pkg.sv
design/slfe_ram.sv
design/slfe_dp.sv
design/slfe_ctrl.sv
design/sync_length_frame_extractor.sv
dv/sync_length_frame_extractor_tb.sv
